// File: hdl/ipbf_pkg.sv
package ipbf_pkg;

    localparam logic [1:0] FUNC_BAN   = 2'd0;
    localparam logic [1:0] FUNC_UNBAN = 2'd1;
    localparam logic [1:0] FUNC_CHECK = 2'd2;
    localparam logic [1:0] FUNC_NOP   = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    localparam logic [31:0] NEVER_ENDS = 32'hFFFF_FFFF;
    localparam logic [5:0]  MAX_PLEN   = 6'd32;
    localparam logic [5:0]  NO_LIVE    = 6'd33;

    localparam int ENTRY_W = 1 + 6 + 32 + 32;

    typedef struct packed {
        logic        valid;
        logic [5:0]  prefix;
        logic [31:0] masked_addr;
        logic [31:0] expiry;
    } t_entry;

    function automatic logic [31:0] prefix_mask(input logic [5:0] plen);
        logic [31:0] m;
        m = '0;
        if (plen >= MAX_PLEN) begin
            m = '1;
        end else if (plen != 6'd0) begin
            m = ~(32'hFFFF_FFFF >> plen);
        end
        return m;
    endfunction

endpackage

// File: hdl/ipbf_req_if.sv
interface ipbf_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [31:0] address;
    logic [5:0]  prefix_len;
    logic [31:0] expiry;
    logic [31:0] now;
    modport source (output valid, func, address, prefix_len, expiry, now, input ready);
    modport sink   (input valid, func, address, prefix_len, expiry, now, output ready);
endinterface

// File: hdl/ipbf_rsp_if.sv
interface ipbf_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic       deny;
    modport source (output valid, status, deny, input ready);
    modport sink   (input valid, status, deny, output ready);
endinterface

// File: hdl/ipbf_cfg_if.sv
interface ipbf_cfg_if;
    logic valid;
    logic ready;
    logic data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// File: hdl/ipbf_ram.sv
module ipbf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// File: hdl/ipv4_prefix_ban_filter_unit.sv
// IPv4 prefix filter table. Each item (ban, unban, check) runs a scan over
// the whole table through a single registered memory read port and a
// single match/compare unit, one entry per cycle. Each entry, valid bit
// included, lives in RAM. After reset a clearing pass zeroes every entry;
// the block is not ready until it ends. Ban and unban scan the table
// (including the read pipeline drain), then write, then load the output.
// A check takes two scans (first finds the shortest live match, second
// drops stale shorter matches) and then loads the output. An unused func
// code skips the scans and goes straight to the output load. The input is
// ready again only after the result is loaded and the wait state has
// passed, so a new item is not taken before the last one is through. The
// result sits in its own output register; the next item is taken and
// processed while it waits, and only the output load of that next item
// stalls until the receiver takes the earlier result.
// r_mode resets to 1; 0 turns the table into an allow list.
module ipv4_prefix_ban_filter_unit
    import ipbf_pkg::*;
#(
    parameter int TABLE_DEPTH = 256
) (
    input  logic i_clk,
    input  logic i_rst_n,
    ipbf_req_if.sink   i_req,
    ipbf_rsp_if.source o_rsp,
    ipbf_cfg_if.sink   i_cfg
);
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] LAST = CW'(TABLE_DEPTH - 1);

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_SCAN1 = 7'b0000100,
        S_SCAN2 = 7'b0001000,
        S_WRITE = 7'b0010000,
        S_OUT   = 7'b0100000,
        S_WAIT  = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    // latched request
    logic [1:0]  r_func;
    logic [31:0] r_addr;
    logic [5:0]  r_plen;
    logic [31:0] r_expiry;
    logic [31:0] r_now;

    logic           r_mode;

    // scan counter, and the index whose read data is now on the RAM output
    logic [CW-1:0]  r_cnt;
    logic           r_rd_vld;
    logic [AW-1:0]  r_rd_idx;

    logic           r_found;
    logic [AW-1:0]  r_found_idx;
    logic           r_free;
    logic [AW-1:0]  r_free_idx;
    logic [5:0]     r_short;

    logic [1:0]     r_status;
    logic           r_deny;

    // output register
    logic [1:0]     r_o_status;
    logic           r_o_deny;
    logic           r_out_vld;

    t_entry ram_rd;
    t_entry ram_wr;
    logic [ENTRY_W-1:0] ram_q;
    logic ram_we;
    logic [AW-1:0] ram_waddr;
    logic [31:0] req_masked;

    assign ram_rd     = t_entry'(ram_q);
    assign req_masked = r_addr & prefix_mask(r_plen);

    ipbf_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wr),
        .i_raddr (r_cnt[AW-1:0]),
        .o_rdata (ram_q)
    );

    // shared match unit on the entry just read
    logic ent_v, key_hit, addr_hit, live, scanning, scan_end, drop, out_load;
    assign scanning = (r_state == S_SCAN1) || (r_state == S_SCAN2);
    assign ent_v    = r_rd_vld && ram_rd.valid;
    assign key_hit  = ent_v && ram_rd.prefix == r_plen && ram_rd.masked_addr == req_masked;
    assign addr_hit = ent_v && ((r_addr & prefix_mask(ram_rd.prefix)) == ram_rd.masked_addr);
    assign live     = (ram_rd.expiry == NEVER_ENDS) || (ram_rd.expiry >= r_now);
    // last entry's data shows up in the cycle after its address
    assign scan_end = r_rd_vld && (r_rd_idx == LAST[AW-1:0]) && (r_cnt == CW'(TABLE_DEPTH));
    // stale match shorter than the shortest live one
    assign drop     = (r_state == S_SCAN2) && addr_hit && !live && (ram_rd.prefix < r_short);
    // result moves to the output register once that register is free
    assign out_load = (r_state == S_OUT) && (!r_out_vld || o_rsp.ready);

    // single write port: clearing pass, stale drop, or ban/unban update
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_found ? r_found_idx : r_free_idx;
        ram_wr    = '0;
        if (r_state == S_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = r_cnt[AW-1:0];
        end else if (drop) begin
            ram_we    = 1'b1;
            ram_waddr = r_rd_idx;
        end else if (r_state == S_WRITE) begin
            if (r_func == FUNC_BAN) begin
                ram_we             = r_found || r_free;
                ram_wr.valid       = 1'b1;
                ram_wr.prefix      = r_plen;
                ram_wr.masked_addr = req_masked;
                ram_wr.expiry      = r_expiry;
            end else begin
                ram_we = r_found;
            end
        end
    end

    assign i_req.ready = (r_state == S_IDLE);
    assign i_cfg.ready = (r_state == S_IDLE);
    assign o_rsp.valid  = r_out_vld;
    assign o_rsp.status = r_o_status;
    assign o_rsp.deny   = r_o_deny;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (r_cnt == LAST) n_state = S_IDLE;
            S_IDLE: begin
                if (i_req.valid && i_req.ready) begin
                    n_state = (i_req.func == FUNC_BAN || i_req.func == FUNC_UNBAN ||
                               i_req.func == FUNC_CHECK) ? S_SCAN1 : S_OUT;
                end
            end
            S_SCAN1: begin
                if (scan_end) begin
                    n_state = (r_func == FUNC_CHECK) ? S_SCAN2 : S_WRITE;
                end
            end
            S_SCAN2: if (scan_end) n_state = S_OUT;
            S_WRITE: n_state = S_OUT;
            S_OUT:   if (out_load) n_state = S_WAIT;
            S_WAIT:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_mode    <= 1'b1;
            r_out_vld <= 1'b0;
            r_cnt     <= '0;
            r_rd_vld  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid && i_cfg.ready) begin
                r_mode <= i_cfg.data;
            end
            if (out_load) begin
                r_out_vld  <= 1'b1;
                r_o_status <= r_status;
                r_o_deny   <= r_deny;
            end else if (o_rsp.valid && o_rsp.ready) begin
                r_out_vld <= 1'b0;
            end

            // address sweep feeding the read port (and the clearing pass)
            r_rd_vld <= scanning && (r_cnt < CW'(TABLE_DEPTH));
            r_rd_idx <= r_cnt[AW-1:0];
            if (r_state == S_CLEAR) begin
                r_cnt <= (r_cnt == LAST) ? '0 : r_cnt + 1'b1;
            end else if (scanning && !scan_end) begin
                if (r_cnt < CW'(TABLE_DEPTH)) r_cnt <= r_cnt + 1'b1;
            end else begin
                r_cnt <= '0;
            end

            unique case (r_state)
                S_CLEAR: ;
                S_IDLE: begin
                    if (i_req.valid && i_req.ready) begin
                        r_func   <= i_req.func;
                        r_addr   <= i_req.address;
                        r_plen   <= (i_req.prefix_len > MAX_PLEN) ? MAX_PLEN : i_req.prefix_len;
                        r_expiry <= i_req.expiry;
                        r_now    <= i_req.now;
                        r_found  <= 1'b0;
                        r_free   <= 1'b0;
                        r_short  <= NO_LIVE;
                        r_status <= ST_OK;
                        r_deny   <= 1'b0;
                    end
                end
                S_SCAN1: begin
                    if (r_rd_vld) begin
                        if (key_hit && !r_found) begin
                            r_found     <= 1'b1;
                            r_found_idx <= r_rd_idx;
                        end
                        if (!ram_rd.valid && !r_free) begin
                            r_free     <= 1'b1;
                            r_free_idx <= r_rd_idx;
                        end
                        if (addr_hit && live && ram_rd.prefix < r_short) begin
                            r_short <= ram_rd.prefix;
                        end
                    end
                end
                S_SCAN2: begin
                    if (scan_end) begin
                        r_deny <= r_mode ? (r_short <= MAX_PLEN) : (r_short > MAX_PLEN);
                    end
                end
                S_WRITE: begin
                    if (r_func == FUNC_BAN) begin
                        if (!r_found && !r_free) r_status <= ST_FULL;
                    end else begin
                        if (!r_found) r_status <= ST_NOT_FOUND;
                    end
                end
                S_OUT:  ;
                S_WAIT: ;
                default: ;
            endcase
        end
    end

    // no new item while a scan is running
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        scanning |-> !i_req.ready) else $error("accept during scan");
    // nothing is taken during the clearing pass
    a_clear_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> (!i_req.ready && !i_cfg.ready)) else $error("accept in clear");
    // a result goes out only from the output step
    a_out_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(r_state == S_OUT)) else $error("stray result");
    // table full reported only for a ban with no free slot
    a_full_ban: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_status == ST_FULL) |->
        (r_func == FUNC_BAN && !r_free && !r_found))
        else $error("bad full");
    // deny is only produced for checks
    a_deny_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_deny) |-> (r_func == FUNC_CHECK)) else $error("bad deny");
endmodule
